[rtl/core/gfp_pkg.sv]
// gfp_pkg: shared types and constants of the gyro frame parser
package gfp_pkg;

  localparam logic [7:0] FrameHeader = 8'h5A;
  localparam logic [7:0] TypeRate    = 8'hAA;
  localparam logic [7:0] TypeYaw     = 8'hBB;

  localparam int unsigned RateWidth = 23;
  localparam int unsigned YawWidth  = 22;

  localparam logic signed [RateWidth-1:0] RateScale = 23'sd125;
  localparam logic signed [YawWidth-1:0]  YawScale  = 22'sd45;

  typedef enum logic [2:0] {
    POS_HEADER = 3'd0,
    POS_TYPE   = 3'd1,
    POS_LOW    = 3'd2,
    POS_HIGH   = 3'd3,
    POS_SUM    = 3'd4
  } pos_e;

  typedef enum logic {
    KIND_RATE = 1'b0,
    KIND_YAW  = 1'b1
  } kind_e;

  typedef struct packed {
    logic               valid;
    kind_e              kind;
    logic signed [15:0] raw;
  } frame_t;

endpackage

[rtl/core/gfp_frame.sv]
// gfp_frame: byte position tracking, capture and checksum of one frame
module gfp_frame
  import gfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       advance_i,
  input  logic [7:0] byte_i,
  output frame_t     frame_o
);

  pos_e       pos_q, pos_d;
  logic [7:0] type_q, type_d;
  logic [7:0] low_q, low_d;
  logic [7:0] high_q, high_d;
  logic [7:0] sum_q, sum_d;
  logic       sum_ok;

  assign sum_ok = (byte_i == sum_q);

  // next state
  always_comb begin
    pos_d = pos_q;
    if (advance_i) begin
      unique case (pos_q)
        POS_HEADER: pos_d = (byte_i == FrameHeader) ? POS_TYPE : POS_HEADER;
        POS_TYPE:   pos_d = POS_LOW;
        POS_LOW:    pos_d = POS_HIGH;
        POS_HIGH:   pos_d = POS_SUM;
        default:    pos_d = POS_HEADER;
      endcase
    end
  end

  // captures and outputs
  always_comb begin
    type_d          = type_q;
    low_d           = low_q;
    high_d          = high_q;
    sum_d           = sum_q;
    frame_o.valid   = 1'b0;
    frame_o.kind    = (type_q == TypeYaw) ? KIND_YAW : KIND_RATE;
    frame_o.raw     = {high_q, low_q};
    if (advance_i) begin
      unique case (pos_q)
        POS_HEADER: begin
          if (byte_i == FrameHeader) begin
            sum_d = byte_i;
          end
        end
        POS_TYPE: begin
          type_d = byte_i;
          sum_d  = sum_q + byte_i;
        end
        POS_LOW: begin
          low_d = byte_i;
          sum_d = sum_q + byte_i;
        end
        POS_HIGH: begin
          high_d = byte_i;
          sum_d  = sum_q + byte_i;
        end
        default: begin
          sum_d         = 8'h00;
          frame_o.valid = sum_ok && ((type_q == TypeRate) || (type_q == TypeYaw));
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= POS_HEADER;
      type_q <= 8'h00;
      low_q  <= 8'h00;
      high_q <= 8'h00;
      sum_q  <= 8'h00;
    end else begin
      pos_q  <= pos_d;
      type_q <= type_d;
      low_q  <= low_d;
      high_q <= high_d;
      sum_q  <= sum_d;
    end
  end

endmodule

[rtl/core/gfp_result.sv]
// gfp_result: scaling, held values and the result register
module gfp_result
  import gfp_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  frame_t                      frame_i,
  input  logic                        take_i,
  output logic                        valid_o,
  output kind_e                       kind_o,
  output logic signed [15:0]          raw_o,
  output logic signed [RateWidth-1:0] rate_o,
  output logic signed [YawWidth-1:0]  yaw_o
);

  logic                        valid_q, valid_d;
  kind_e                       kind_q;
  logic signed [15:0]          raw_q;
  logic signed [RateWidth-1:0] rate_q, rate_d;
  logic signed [YawWidth-1:0]  yaw_q, yaw_d;
  logic signed [RateWidth-1:0] held_rate_q;
  logic signed [YawWidth-1:0]  held_yaw_q;
  logic signed [RateWidth-1:0] rate_prod;
  logic signed [YawWidth-1:0]  yaw_prod;

  assign rate_prod = RateWidth'(frame_i.raw) * RateScale;
  assign yaw_prod  = YawWidth'(frame_i.raw) * YawScale;

  always_comb begin
    rate_d = held_rate_q;
    yaw_d  = held_yaw_q;
    if (frame_i.kind == KIND_RATE) begin
      rate_d = rate_prod;
    end else begin
      yaw_d = yaw_prod;
    end
  end

  assign valid_d = frame_i.valid ? 1'b1 : (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      held_rate_q <= '0;
      held_yaw_q  <= '0;
    end else begin
      valid_q <= valid_d;
      if (frame_i.valid) begin
        held_rate_q <= rate_d;
        held_yaw_q  <= yaw_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.valid) begin
      kind_q <= frame_i.kind;
      raw_q  <= frame_i.raw;
      rate_q <= rate_d;
      yaw_q  <= yaw_d;
    end
  end

  assign valid_o = valid_q;
  assign kind_o  = kind_q;
  assign raw_o   = raw_q;
  assign rate_o  = rate_q;
  assign yaw_o   = yaw_q;

endmodule

[rtl/core/gyro_frame_parser_top.sv]
// gyro_frame_parser_top: serial gyro frame parser, byte in, scaled result out
//
//   channel | valid      | stall       | payload
//   --------+------------+-------------+-------------------------------------------
//   in      | in_valid_i | in_stall_o  | rx_byte_i
//   out     | out_valid_o| out_stall_i | frame_kind_o raw_value_o rate_value_o yaw_value_o
//
// one byte per cycle unless the output stalls; a byte waits in the input register and
// a result appears in the result register the cycle after its checksum byte leaves it
// reset clears the byte position, the held rate and yaw and both valid flags
// while a result waits under stall, one more byte is still taken into the
// input register; further requests stall until the result is taken
module gyro_frame_parser_top
  import gfp_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        frame_kind_o,
  output logic signed [15:0]          raw_value_o,
  output logic signed [RateWidth-1:0] rate_value_o,
  output logic signed [YawWidth-1:0]  yaw_value_o
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       consume;
  logic       in_accept;
  frame_t     frame;
  kind_e      kind;

  assign consume    = in_valid_q && (!out_valid_o || !out_stall_i);
  assign in_stall_o = in_valid_q && !consume;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_valid_d = in_accept || (in_valid_q && !consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= rx_byte_i;
    end
  end

  gfp_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (consume),
    .byte_i    (byte_q),
    .frame_o   (frame)
  );

  gfp_result u_result (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .frame_i (frame),
    .take_i  (!out_stall_i),
    .valid_o (out_valid_o),
    .kind_o  (kind),
    .raw_o   (raw_value_o),
    .rate_o  (rate_value_o),
    .yaw_o   (yaw_value_o)
  );

  assign frame_kind_o = kind;

  a_frame_needs_consume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame.valid |-> consume)
    else $error("frame completed without a consumed byte");

  a_result_after_consume: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(consume))
    else $error("result appeared without a consumed byte");

  a_rate_scaled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind == KIND_RATE)) |->
      (rate_value_o == RateWidth'(raw_value_o) * RateScale))
    else $error("rate result does not match its data word");

  a_yaw_scaled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind == KIND_YAW)) |->
      (yaw_value_o == YawWidth'(raw_value_o) * YawScale))
    else $error("yaw result does not match its data word");

endmodule
